// ===== src/rtplt_pkg.sv =====
// shared types and constants for the rtp relay latch table
package rtplt_pkg;

    localparam int NUM_PORTS = 1024;
    localparam int PORT_W    = $clog2(NUM_PORTS);
    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

    localparam logic [15:0] IDLE_LIMIT_RST = 16'd30;

    typedef enum logic [1:0] {
        ACT_DROP = 2'd0,
        ACT_FWD  = 2'd1,
        ACT_REL  = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        PH_EMPTY  = 2'd0,
        PH_HALF   = 2'd1,
        PH_ACTIVE = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        KIND_PKT_OTHER = 2'd0,
        KIND_PKT_RTP   = 2'd1,
        KIND_TICK_EVEN = 2'd2,
        KIND_TICK_ODD  = 2'd3
    } t_kind;

    typedef struct packed {
        logic        req_type;
        logic [9:0]  port_index;
        logic [31:0] src_addr;
        logic [15:0] src_port;
        logic        packet_is_rtp;
    } t_in_item;

    typedef struct packed {
        t_action     action;
        logic [31:0] dest_addr;
        logic [15:0] dest_port;
        logic [9:0]  out_port_index;
    } t_out_item;

    typedef struct packed {
        t_kind       kind;
        logic [9:0]  port_index;
        logic [31:0] src_addr;
        logic [15:0] src_port;
    } t_cmd;

    typedef struct packed {
        t_phase      phase;
        logic [31:0] a_addr;
        logic [15:0] a_port;
        logic [31:0] b_addr;
        logic [15:0] b_port;
        logic [15:0] idle;
    } t_entry;

endpackage

// ===== src/rtplt_front.sv =====
// input stage: accepts items and classifies them into commands
module rtplt_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  rtplt_pkg::t_in_item i_in,
    input  logic                i_clearing,
    input  logic                i_q_full,
    output logic                o_q_push,
    output rtplt_pkg::t_cmd     o_cmd
);

    logic            r_valid;
    rtplt_pkg::t_cmd r_cmd;
    rtplt_pkg::t_cmd n_cmd;
    logic            in_ready;
    logic            accept;

    assign o_q_push = r_valid && !i_q_full;
    assign in_ready = !i_clearing && (!r_valid || !i_q_full);
    assign full     = !in_ready;
    assign accept   = push && in_ready;
    assign o_cmd    = r_cmd;

    always_comb begin
        n_cmd.port_index = i_in.port_index;
        n_cmd.src_addr   = i_in.src_addr;
        n_cmd.src_port   = i_in.src_port;
        if (i_in.req_type) begin
            n_cmd.kind = i_in.port_index[0] ? rtplt_pkg::KIND_TICK_ODD
                                            : rtplt_pkg::KIND_TICK_EVEN;
        end else begin
            n_cmd.kind = i_in.packet_is_rtp ? rtplt_pkg::KIND_PKT_RTP
                                            : rtplt_pkg::KIND_PKT_OTHER;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_q_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

// ===== src/rtplt_queue.sv =====
// command queue between the front stage and the table engine
module rtplt_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  rtplt_pkg::t_cmd i_cmd,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output rtplt_pkg::t_cmd o_cmd
);

    rtplt_pkg::t_cmd                    r_mem [rtplt_pkg::Q_DEPTH];
    logic [rtplt_pkg::Q_PTR_W-1:0]      r_wptr;
    logic [rtplt_pkg::Q_PTR_W-1:0]      r_rptr;
    logic [rtplt_pkg::Q_CNT_W-1:0]      r_count;
    logic                               do_push;
    logic                               do_pop;

    assign o_full  = r_count == rtplt_pkg::Q_CNT_W'(rtplt_pkg::Q_DEPTH);
    assign o_empty = r_count == '0;
    assign o_cmd   = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

endmodule

// ===== src/rtplt_back.sv =====
// table engine: clears the table, then runs one read-modify-write per command
module rtplt_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [15:0]          i_cfg_wdata,
    input  logic                 i_q_empty,
    input  rtplt_pkg::t_cmd      i_cmd,
    output logic                 o_q_pop,
    output logic                 o_clearing,
    output logic                 empty,
    input  logic                 pop,
    output rtplt_pkg::t_out_item o_out
);

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_EXEC  = 3'b100
    } t_state;

    t_state                     r_state;
    t_state                     n_state;
    logic [rtplt_pkg::PORT_W-1:0] r_clr_idx;
    logic [15:0]                r_idle_limit;
    rtplt_pkg::t_entry          r_mem [rtplt_pkg::NUM_PORTS];
    rtplt_pkg::t_entry          r_rd_data;
    rtplt_pkg::t_cmd            r_cmd;
    rtplt_pkg::t_out_item       r_out;
    logic                       r_out_valid;
    rtplt_pkg::t_entry          n_ent;
    rtplt_pkg::t_out_item       n_out;
    logic                       out_pop;
    logic                       issue;
    logic                       from_a;
    logic                       from_b;
    logic                       wr_en;
    logic [rtplt_pkg::PORT_W-1:0] wr_addr;
    rtplt_pkg::t_entry          wr_data;

    assign out_pop    = pop && r_out_valid;
    assign issue      = (r_state == S_IDLE) && !i_q_empty && (!r_out_valid || out_pop);
    assign o_q_pop    = issue;
    assign o_clearing = r_state == S_CLEAR;
    assign empty      = !r_out_valid;
    assign o_out      = r_out;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_idx == rtplt_pkg::PORT_W'(rtplt_pkg::NUM_PORTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (issue) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // per-entry update and result
    always_comb begin
        from_a = (r_rd_data.a_addr == r_cmd.src_addr) && (r_rd_data.a_port == r_cmd.src_port);
        from_b = (r_rd_data.b_addr == r_cmd.src_addr) && (r_rd_data.b_port == r_cmd.src_port);
        n_ent  = r_rd_data;
        n_out.action         = rtplt_pkg::ACT_DROP;
        n_out.dest_addr      = '0;
        n_out.dest_port      = '0;
        n_out.out_port_index = r_cmd.port_index;
        unique case (r_cmd.kind) inside
            rtplt_pkg::KIND_TICK_EVEN: begin
                if (r_rd_data.phase == rtplt_pkg::PH_ACTIVE) begin
                    if (r_rd_data.idle < r_idle_limit) begin
                        n_ent.idle = r_rd_data.idle + 16'd1;
                    end else begin
                        n_out.action = rtplt_pkg::ACT_REL;
                    end
                end
            end
            rtplt_pkg::KIND_PKT_RTP, rtplt_pkg::KIND_PKT_OTHER: begin
                unique case (r_rd_data.phase)
                    rtplt_pkg::PH_ACTIVE: begin
                        if (from_a) begin
                            n_out.action    = rtplt_pkg::ACT_FWD;
                            n_out.dest_addr = r_rd_data.b_addr;
                            n_out.dest_port = r_rd_data.b_port;
                        end else if (from_b) begin
                            n_out.action    = rtplt_pkg::ACT_FWD;
                            n_out.dest_addr = r_rd_data.a_addr;
                            n_out.dest_port = r_rd_data.a_port;
                        end
                    end
                    rtplt_pkg::PH_EMPTY: begin
                        if (r_cmd.kind == rtplt_pkg::KIND_PKT_RTP) begin
                            n_ent.a_addr = r_cmd.src_addr;
                            n_ent.a_port = r_cmd.src_port;
                            n_ent.phase  = rtplt_pkg::PH_HALF;
                        end
                    end
                    rtplt_pkg::PH_HALF: begin
                        if (!from_a && r_cmd.kind == rtplt_pkg::KIND_PKT_RTP) begin
                            n_ent.b_addr = r_cmd.src_addr;
                            n_ent.b_port = r_cmd.src_port;
                            n_ent.phase  = rtplt_pkg::PH_ACTIVE;
                        end
                    end
                    default: begin
                        n_ent.phase = r_rd_data.phase;
                    end
                endcase
                n_ent.idle = '0;
            end
            default: begin
                n_ent = r_rd_data;
            end
        endcase
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_cmd.port_index;
        wr_data = n_ent;
        if (r_state == S_CLEAR) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_idx;
            wr_data = '0;
        end else if (r_state == S_EXEC) begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_idx    <= '0;
            r_idle_limit <= rtplt_pkg::IDLE_LIMIT_RST;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            if (i_cfg_we) begin
                r_idle_limit <= i_cfg_wdata;
            end
            if (r_state == S_EXEC) begin
                r_out_valid <= 1'b1;
            end else if (out_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (issue) begin
            r_rd_data <= r_mem[i_cmd.port_index];
            r_cmd     <= i_cmd;
        end
        if (r_state == S_EXEC) begin
            r_out <= n_out;
        end
    end

endmodule

// ===== src/rtp_relay_latch_table_top.sv =====
// rtp relay latch table: learns two endpoints per relay port and relays between them
// path: an item is registered in the front stage and queued; the engine takes a new
// command only once the result register is free and the last read-modify-write on
// the single-port table is done (read at issue, update and result in the next)
// reset: a clearing pass zeroes all 1024 table entries, with full held high
// the idle limit register resets to 30
module rtp_relay_latch_table_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  rtplt_pkg::t_in_item  i_in,
    output logic                 empty,
    input  logic                 pop,
    output rtplt_pkg::t_out_item o_out,
    input  logic                 i_cfg_we,
    input  logic [15:0]          i_cfg_wdata
);

    logic            clearing;
    logic            q_full;
    logic            q_push;
    logic            q_empty;
    logic            q_pop;
    rtplt_pkg::t_cmd front_cmd;
    rtplt_pkg::t_cmd head_cmd;

    rtplt_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in       (i_in),
        .i_clearing (clearing),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_cmd      (front_cmd)
    );

    rtplt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_cmd   (head_cmd)
    );

    rtplt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_empty   (q_empty),
        .i_cmd       (head_cmd),
        .o_q_pop     (q_pop),
        .o_clearing  (clearing),
        .empty       (empty),
        .pop         (pop),
        .o_out       (o_out)
    );

endmodule

// ===== src/rtplt_checker.sv =====
// port-level checks for the rtp relay latch table, bound to the top level
module rtplt_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 full,
    input logic                 empty,
    input logic                 pop,
    input rtplt_pkg::t_out_item o_out
);

    a_action_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_out.action == rtplt_pkg::ACT_DROP
                 || o_out.action == rtplt_pkg::ACT_FWD
                 || o_out.action == rtplt_pkg::ACT_REL))
        else $error("illegal action code");

    a_dest_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out.action != rtplt_pkg::ACT_FWD)
            |-> (o_out.dest_addr == '0 && o_out.dest_port == '0))
        else $error("destination set on a non-forward result");

    a_release_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out.action == rtplt_pkg::ACT_REL) |-> !o_out.out_port_index[0])
        else $error("release reported on an odd port");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out)))
        else $error("waiting result changed");

    a_reset_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> (full && empty))
        else $error("block not clearing after reset");

endmodule

bind rtp_relay_latch_table_top rtplt_checker u_rtplt_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .full    (full),
    .empty   (empty),
    .pop     (pop),
    .o_out   (o_out)
);

// ===== verif/tb_rtp_relay_latch_table_top.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the rtp relay latch table: directed table, random traffic, scoreboard
module tb_rtp_relay_latch_table_top;

    localparam logic REQ_PKT  = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    localparam logic [31:0] A_ADDR = 32'hFFFF_FFFF;
    localparam logic [15:0] A_PORT = 16'hFFFF;
    localparam logic [31:0] B_ADDR = 32'h0000_0000;
    localparam logic [15:0] B_PORT = 16'h0000;
    localparam logic [31:0] C_ADDR = 32'h1234_5678;
    localparam logic [15:0] C_PORT = 16'h8000;

    localparam int ITEMS_PER_PHASE = 200;
    localparam int NUM_PHASES      = 7;

    typedef struct {
        logic                 is_cfg;
        logic [15:0]          cfg_val;
        rtplt_pkg::t_in_item  item;
        logic                 typed;
        rtplt_pkg::t_out_item want;
    } t_dir_row;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 push        = 1'b0;
    logic                 full;
    rtplt_pkg::t_in_item  i_in        = '0;
    logic                 empty;
    logic                 pop         = 1'b0;
    rtplt_pkg::t_out_item o_out;
    logic                 i_cfg_we    = 1'b0;
    logic [15:0]          i_cfg_wdata = '0;

    rtplt_pkg::t_phase tbl_phase  [rtplt_pkg::NUM_PORTS];
    logic [31:0]       tbl_a_addr [rtplt_pkg::NUM_PORTS];
    logic [15:0]       tbl_a_port [rtplt_pkg::NUM_PORTS];
    logic [31:0]       tbl_b_addr [rtplt_pkg::NUM_PORTS];
    logic [15:0]       tbl_b_port [rtplt_pkg::NUM_PORTS];
    logic [15:0]       tbl_idle   [rtplt_pkg::NUM_PORTS];
    logic [15:0]       idle_limit_sh = rtplt_pkg::IDLE_LIMIT_RST;

    rtplt_pkg::t_out_item verdict_q [$];
    rtplt_pkg::t_out_item want_now;
    t_dir_row             dir_rows  [$];
    int                   errors = 0;

    int          send_idle_pct = 20;
    int          pop_idle_pct  = 20;
    int          pop_hold      = 0;
    int          pct_choice [4] = '{0, 10, 25, 50};

    logic [9:0]  pool_port  [8];
    logic [31:0] pool_addr  [8][2];
    logic [15:0] pool_sport [8][2];

    rtp_relay_latch_table_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in        (i_in),
        .empty       (empty),
        .pop         (pop),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        errors++;
        $display("ERROR @%0t: %s", $time, what);
    endtask

    // relay table behavior: updates the shadow table and returns the verdict
    function automatic rtplt_pkg::t_out_item predict_verdict(input rtplt_pkg::t_in_item it);
        rtplt_pkg::t_out_item v;
        logic [9:0]           idx;
        logic                 from_a;
        logic                 from_b;
        v                = '0;
        v.action         = rtplt_pkg::ACT_DROP;
        v.out_port_index = it.port_index;
        idx              = it.port_index;
        from_a = tbl_a_addr[idx] == it.src_addr && tbl_a_port[idx] == it.src_port;
        from_b = tbl_b_addr[idx] == it.src_addr && tbl_b_port[idx] == it.src_port;
        if (it.req_type == REQ_TICK) begin
            if (!idx[0] && tbl_phase[idx] == rtplt_pkg::PH_ACTIVE) begin
                if (tbl_idle[idx] < idle_limit_sh) begin
                    tbl_idle[idx] = tbl_idle[idx] + 16'd1;
                end else begin
                    v.action = rtplt_pkg::ACT_REL;
                end
            end
        end else begin
            case (tbl_phase[idx])
                rtplt_pkg::PH_ACTIVE: begin
                    if (from_a) begin
                        v.action    = rtplt_pkg::ACT_FWD;
                        v.dest_addr = tbl_b_addr[idx];
                        v.dest_port = tbl_b_port[idx];
                    end else if (from_b) begin
                        v.action    = rtplt_pkg::ACT_FWD;
                        v.dest_addr = tbl_a_addr[idx];
                        v.dest_port = tbl_a_port[idx];
                    end
                end
                rtplt_pkg::PH_EMPTY: begin
                    if (it.packet_is_rtp) begin
                        tbl_a_addr[idx] = it.src_addr;
                        tbl_a_port[idx] = it.src_port;
                        tbl_phase[idx]  = rtplt_pkg::PH_HALF;
                    end
                end
                rtplt_pkg::PH_HALF: begin
                    if (!from_a && it.packet_is_rtp) begin
                        tbl_b_addr[idx] = it.src_addr;
                        tbl_b_port[idx] = it.src_port;
                        tbl_phase[idx]  = rtplt_pkg::PH_ACTIVE;
                    end
                end
                default: begin
                end
            endcase
            tbl_idle[idx] = '0;
        end
        return v;
    endfunction

    function automatic void add_row(input logic req, input logic [9:0] idx,
                                    input logic [31:0] addr, input logic [15:0] sport,
                                    input logic rtp, input logic typed,
                                    input rtplt_pkg::t_action act,
                                    input logic [31:0] daddr, input logic [15:0] dport);
        t_dir_row row;
        row.is_cfg  = 1'b0;
        row.cfg_val = '0;
        row.item    = '{req_type: req, port_index: idx, src_addr: addr, src_port: sport,
                        packet_is_rtp: rtp};
        row.typed   = typed;
        row.want    = '{action: act, dest_addr: daddr, dest_port: dport, out_port_index: idx};
        dir_rows.push_back(row);
    endfunction

    function automatic void add_cfg(input logic [15:0] val);
        t_dir_row row;
        row         = '{is_cfg: 1'b1, cfg_val: val, item: '0, typed: 1'b0, want: '0};
        dir_rows.push_back(row);
    endfunction

    function automatic rtplt_pkg::t_in_item next_random_item();
        rtplt_pkg::t_in_item it;
        int                  r;
        int                  k;
        r                = $urandom_range(99);
        k                = $urandom_range(7);
        it.req_type      = 1'($urandom_range(1));
        it.port_index    = 10'($urandom);
        it.src_addr      = $urandom;
        it.src_port      = 16'($urandom);
        it.packet_is_rtp = ($urandom_range(1) != 0);
        if (r < 50) begin
            it.req_type      = REQ_PKT;
            it.port_index    = pool_port[k];
            it.src_addr      = pool_addr[k][r % 2];
            it.src_port      = pool_sport[k][r % 2];
            it.packet_is_rtp = ($urandom_range(9) != 0);
        end else if (r < 60) begin
            it.req_type   = REQ_PKT;
            it.port_index = pool_port[k];
        end else if (r < 85) begin
            it.req_type   = REQ_TICK;
            it.port_index = pool_port[k];
        end
        return it;
    endfunction

    task automatic send_item(input rtplt_pkg::t_in_item it, input logic typed,
                             input rtplt_pkg::t_out_item want);
        @(negedge i_clk);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        push <= 1'b1;
        i_in <= it;
        do @(posedge i_clk); while (full !== 1'b0);
        want = typed ? want : predict_verdict(it);
        if (typed) begin
            void'(predict_verdict(it));
        end
        verdict_q.push_back(want);
    endtask

    task automatic write_limit(input logic [15:0] val);
        @(negedge i_clk);
        push <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        idle_limit_sh = val;
    endtask

    // result side stalls
    always @(negedge i_clk) begin
        if (pop_hold > 0) begin
            pop_hold--;
        end else if (pop_idle_pct != 0 && $urandom_range(99) < pop_idle_pct) begin
            pop      <= 1'b0;
            pop_hold  = $urandom_range(1, 6) - 1;
        end else begin
            pop <= 1'b1;
        end
    end

    // transaction checker
    always @(posedge i_clk) begin
        if (i_rst_n && pop && empty === 1'b0) begin
            if (verdict_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result for port %0d",
                                          o_out.out_port_index));
            end else begin
                want_now = verdict_q.pop_front();
                if (o_out.action !== want_now.action) begin
                    report_mismatch($sformatf("port %0d action: got %0d want %0d",
                        want_now.out_port_index, o_out.action, want_now.action));
                end
                if (o_out.dest_addr !== want_now.dest_addr) begin
                    report_mismatch($sformatf("port %0d dest_addr: got %h want %h",
                        want_now.out_port_index, o_out.dest_addr, want_now.dest_addr));
                end
                if (o_out.dest_port !== want_now.dest_port) begin
                    report_mismatch($sformatf("port %0d dest_port: got %h want %h",
                        want_now.out_port_index, o_out.dest_port, want_now.dest_port));
                end
                if (o_out.out_port_index !== want_now.out_port_index) begin
                    report_mismatch($sformatf("out_port_index: got %0d want %0d",
                        o_out.out_port_index, want_now.out_port_index));
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    initial begin
        for (int p = 0; p < rtplt_pkg::NUM_PORTS; p++) begin
            tbl_phase[p]  = rtplt_pkg::PH_EMPTY;
            tbl_a_addr[p] = '0;
            tbl_a_port[p] = '0;
            tbl_b_addr[p] = '0;
            tbl_b_port[p] = '0;
            tbl_idle[p]   = '0;
        end

        // learning, relay, idle counting and limits
        add_row(REQ_PKT,  10'd0,    A_ADDR, A_PORT, 1'b1, 1'b1, rtplt_pkg::ACT_DROP, '0, '0);
        add_row(REQ_PKT,  10'd0,    C_ADDR, C_PORT, 1'b0, 1'b0, rtplt_pkg::ACT_DROP, '0, '0);
        add_row(REQ_PKT,  10'd0,    A_ADDR, A_PORT, 1'b1, 1'b0, rtplt_pkg::ACT_DROP, '0, '0);
        add_row(REQ_PKT,  10'd0,    B_ADDR, B_PORT, 1'b1, 1'b0, rtplt_pkg::ACT_DROP, '0, '0);
        add_row(REQ_PKT,  10'd0,    A_ADDR, A_PORT, 1'b0, 1'b1, rtplt_pkg::ACT_FWD,
                B_ADDR, B_PORT);
        add_row(REQ_PKT,  10'd0,    B_ADDR, B_PORT, 1'b1, 1'b1, rtplt_pkg::ACT_FWD,
                A_ADDR, A_PORT);
        add_row(REQ_PKT,  10'd0,    C_ADDR, C_PORT, 1'b1, 1'b1, rtplt_pkg::ACT_DROP, '0, '0);
        add_row(REQ_TICK, 10'd0,    A_ADDR, A_PORT, 1'b1, 1'b0, rtplt_pkg::ACT_DROP, '0, '0);
        add_cfg(16'd0);
        add_row(REQ_TICK, 10'd0,    B_ADDR, B_PORT, 1'b0, 1'b1, rtplt_pkg::ACT_REL, '0, '0);
        add_row(REQ_PKT,  10'd0,    A_ADDR, A_PORT, 1'b1, 1'b0, rtplt_pkg::ACT_DROP, '0, '0);
        add_row(REQ_TICK, 10'd0,    C_ADDR, C_PORT, 1'b0, 1'b1, rtplt_pkg::ACT_REL, '0, '0);
        add_row(REQ_PKT,  10'd1023, C_ADDR, C_PORT, 1'b1, 1'b0, rtplt_pkg::ACT_DROP, '0, '0);
        add_row(REQ_PKT,  10'd1023, A_ADDR, A_PORT, 1'b1, 1'b0, rtplt_pkg::ACT_DROP, '0, '0);
        add_row(REQ_TICK, 10'd1023, A_ADDR, A_PORT, 1'b1, 1'b1, rtplt_pkg::ACT_DROP, '0, '0);
        add_row(REQ_TICK, 10'd2,    A_ADDR, A_PORT, 1'b1, 1'b1, rtplt_pkg::ACT_DROP, '0, '0);
        add_cfg(16'hFFFF);
        add_row(REQ_TICK, 10'd0,    A_ADDR, A_PORT, 1'b0, 1'b0, rtplt_pkg::ACT_DROP, '0, '0);
        add_cfg(16'd1);
        add_row(REQ_TICK, 10'd0,    B_ADDR, B_PORT, 1'b1, 1'b0, rtplt_pkg::ACT_DROP, '0, '0);
        add_row(REQ_TICK, 10'd0,    C_ADDR, C_PORT, 1'b0, 1'b0, rtplt_pkg::ACT_DROP, '0, '0);
        add_row(REQ_PKT,  10'd4,    A_ADDR, A_PORT, 1'b0, 1'b1, rtplt_pkg::ACT_DROP, '0, '0);
        add_row(REQ_PKT,  10'd4,    A_ADDR, A_PORT, 1'b1, 1'b0, rtplt_pkg::ACT_DROP, '0, '0);
        add_row(REQ_PKT,  10'd4,    A_ADDR, A_PORT, 1'b1, 1'b0, rtplt_pkg::ACT_DROP, '0, '0);

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_cfg) begin
                write_limit(dir_rows[i].cfg_val);
            end else begin
                send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
            end
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0:       write_limit(16'd5);
                1:       write_limit(16'd0);
                2:       write_limit(16'hFFFF);
                3:       write_limit(16'd2);
                4:       write_limit(16'd30);
                5:       write_limit(16'd9);
                default: write_limit(16'd1);
            endcase
            for (int k = 0; k < 8; k++) begin
                pool_port[k]     = {9'($urandom_range(511)), k[0]};
                pool_addr[k][0]  = $urandom;
                pool_sport[k][0] = 16'($urandom);
                pool_addr[k][1]  = ($urandom_range(3) == 0) ? pool_addr[k][0] : $urandom;
                pool_sport[k][1] = 16'($urandom);
            end
            if (ph == NUM_PHASES - 1) begin
                send_idle_pct = 0;
                pop_idle_pct  = 0;
            end else begin
                send_idle_pct = pct_choice[$urandom_range(3)];
                pop_idle_pct  = pct_choice[$urandom_range(3)];
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                send_item(next_random_item(), 1'b0, '0);
            end
        end

        @(negedge i_clk);
        push <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/rtplt_pkg.sv
src/rtplt_front.sv
src/rtplt_queue.sv
src/rtplt_back.sv
src/rtp_relay_latch_table_top.sv
src/rtplt_checker.sv
verif/tb_rtp_relay_latch_table_top.sv
